/* rtl/key_debounce_long_press_core_assert.svh */
// Assertion macros shared by the key debounce RTL.
`ifndef KEY_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KDLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KDLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kdlp_pkg.sv */
// Shared types and widths for the key debounce core.
package kdlp_pkg;

  localparam int unsigned KeyW   = 4;
  localparam int unsigned EventW = 6;

  typedef struct packed {
    logic        long_enable;
    logic [7:0]  press_confirm_count;
    logic [7:0]  short_release_count;
    logic [15:0] long_hold_count;
    logic [7:0]  long_release_count;
  } cfg_t;

  typedef struct packed {
    logic            busy;
    logic [KeyW-1:0] held_key;
  } stat_t;

endpackage

/* rtl/kdlp_fsm.sv */
// Key scan and debounce phase machine, one step per accepted sample.
module kdlp_fsm #(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kdlp_pkg::cfg_t              cfg_i,
  input  logic                        step_i,
  input  logic [7:0]                  pins_i,
  output logic [kdlp_pkg::EventW-1:0] event_o,
  output kdlp_pkg::stat_t             stat_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CHECK = 2'd1,
    PH_HELD  = 2'd2,
    PH_LONG  = 2'd3
  } phase_e;

  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvPress    = 3'd1;
  localparam logic [2:0] EvLong     = 3'd2;
  localparam logic [2:0] EvShortRel = 3'd3;
  localparam logic [2:0] EvLongRel  = 3'd4;

  phase_e                    phase_q, phase_d;
  logic [kdlp_pkg::KeyW-1:0] held_key_q, held_key_d;
  logic [7:0]                sample_cnt_q, sample_cnt_d;
  logic [15:0]               hold_cnt_q, hold_cnt_d;

  logic [kdlp_pkg::KeyW-1:0] key;
  logic                      key_match;
  logic                      strict;
  logic [7:0]                sample_inc;
  logic [15:0]               hold_inc;
  logic [2:0]                ev_kind;
  logic [kdlp_pkg::EventW-1:0] ev_base;

  function automatic logic reached(input logic [7:0] cnt, input logic [7:0] lim,
                                   input logic strict_cmp);
    return strict_cmp ? (cnt > lim) : (cnt >= lim);
  endfunction

  // Lowest-numbered pressed key wins; pins are active low.
  always_comb begin
    key = '0;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (!pins_i[i]) begin
        key = kdlp_pkg::KeyW'(i + 1);
      end
    end
  end

  assign key_match  = (key == held_key_q);
  assign strict     = cfg_i.long_enable;
  assign sample_inc = (sample_cnt_q == 8'hFF) ? sample_cnt_q : sample_cnt_q + 8'd1;
  assign hold_inc   = (hold_cnt_q == 16'hFFFF) ? hold_cnt_q : hold_cnt_q + 16'd1;

  always_comb begin
    phase_d      = phase_q;
    held_key_d   = held_key_q;
    sample_cnt_d = sample_cnt_q;
    hold_cnt_d   = hold_cnt_q;
    ev_kind      = EvNone;
    case (phase_q)
      PH_IDLE: begin
        if (key != '0) begin
          sample_cnt_d = '0;
          held_key_d   = key;
          phase_d      = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (!key_match) begin
          phase_d = PH_IDLE;
        end else begin
          sample_cnt_d = sample_inc;
          if (reached(sample_inc, cfg_i.press_confirm_count, strict)) begin
            sample_cnt_d = '0;
            hold_cnt_d   = '0;
            phase_d      = PH_HELD;
            ev_kind      = EvPress;
          end
        end
      end
      PH_HELD: begin
        if (strict) begin
          hold_cnt_d = hold_inc;
        end
        // A long press takes priority over any release in the same sample.
        if (strict && (hold_inc > cfg_i.long_hold_count)) begin
          sample_cnt_d = '0;
          phase_d      = PH_LONG;
          ev_kind      = EvLong;
        end else if (!key_match) begin
          sample_cnt_d = sample_inc;
          if (reached(sample_inc, cfg_i.short_release_count, strict)) begin
            phase_d = PH_IDLE;
            ev_kind = EvShortRel;
          end
        end else begin
          sample_cnt_d = '0;
        end
      end
      PH_LONG: begin
        if (!key_match) begin
          sample_cnt_d = sample_inc;
          if (sample_inc > cfg_i.long_release_count) begin
            phase_d = PH_IDLE;
            ev_kind = EvLongRel;
          end
        end else begin
          sample_cnt_d = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign ev_base = {1'b0, held_key_q[2:0] - 3'd1, 2'b00};
  assign event_o = (ev_kind == EvNone) ? '0 : ev_base + {3'b000, ev_kind};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      held_key_q   <= '0;
      sample_cnt_q <= '0;
      hold_cnt_q   <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      held_key_q   <= held_key_d;
      sample_cnt_q <= sample_cnt_d;
      hold_cnt_q   <= hold_cnt_d;
    end
  end

  assign stat_o.busy     = (phase_q != PH_IDLE);
  assign stat_o.held_key = held_key_q;

endmodule

/* rtl/key_debounce_long_press_core.sv */
// Top level: APB registers, sample stream in, key event stream out.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tdata[7:0]  key_pins
//   m_axis    out  m_axis_tvalid/tready       tdata[5:0]  key_event
//   apb       in   psel/penable/pready        paddr[4:2]  register index
//
// Each sample is stepped through the phase machine at the accepting edge, and
// its event sits in the output register the cycle after.
// One sample per cycle is sustained while the output is drained.
// A stalled output blocks input only when its register is full and not taken.
// Reset returns the machine to idle and loads the register defaults.
module key_debounce_long_press_core #(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_pins
  // Event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [5:0] key_event, [7:6] zero
);

  localparam logic [2:0] RegLongEnable   = 3'd0;
  localparam logic [2:0] RegPressConfirm = 3'd1;
  localparam logic [2:0] RegShortRelease = 3'd2;
  localparam logic [2:0] RegLongHold     = 3'd3;
  localparam logic [2:0] RegLongRelease  = 3'd4;

  kdlp_pkg::cfg_t              cfg_q;
  kdlp_pkg::stat_t             stat;
  logic [kdlp_pkg::EventW-1:0] event_d, event_q;
  logic                        out_valid_q;
  logic                        in_fire;
  logic                        cfg_wr;
  logic [2:0]                  reg_idx;
  logic                        held_key_ok;
  logic                        event_key_ok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_enable         <= 1'b1;
      cfg_q.press_confirm_count <= 8'd3;
      cfg_q.short_release_count <= 8'd3;
      cfg_q.long_hold_count     <= 16'd250;
      cfg_q.long_release_count  <= 8'd3;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegLongEnable:   cfg_q.long_enable         <= pwdata[0];
        RegPressConfirm: cfg_q.press_confirm_count <= pwdata[7:0];
        RegShortRelease: cfg_q.short_release_count <= pwdata[7:0];
        RegLongHold:     cfg_q.long_hold_count     <= pwdata[15:0];
        RegLongRelease:  cfg_q.long_release_count  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegLongEnable:   prdata = {31'd0, cfg_q.long_enable};
      RegPressConfirm: prdata = {24'd0, cfg_q.press_confirm_count};
      RegShortRelease: prdata = {24'd0, cfg_q.short_release_count};
      RegLongHold:     prdata = {16'd0, cfg_q.long_hold_count};
      RegLongRelease:  prdata = {24'd0, cfg_q.long_release_count};
      default:         prdata = '0;
    endcase
  end

  // Accept whenever the output register is empty or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  kdlp_fsm #(
    .KEY_COUNT(KEY_COUNT)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (in_fire),
    .pins_i (s_axis_tdata),
    .event_o(event_d),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, event_q};

  assign held_key_ok  = (stat.held_key != '0) && (stat.held_key <= kdlp_pkg::KeyW'(KEY_COUNT));
  assign event_key_ok = (event_q == '0) || (((event_q - 6'd1) >> 2) < 6'(KEY_COUNT));

`include "key_debounce_long_press_core_assert.svh"

  `KDLP_ASSERT_NEXT(a_fire_fills_out, in_fire, m_axis_tvalid, "accepted sample left no event")
  `KDLP_ASSERT_NOW(a_stall_only_full, !s_axis_tready, out_valid_q, "input stalled with empty output")
  `KDLP_ASSERT_NOW(a_held_key_range, stat.busy, held_key_ok, "held key out of range")
  `KDLP_ASSERT_NOW(a_event_key_range, m_axis_tvalid, event_key_ok, "event names a missing key")

endmodule
